// ----- sv/rwam_pkg.sv -----
// shared constants, codes and types of the refcounted window address mapper
`default_nettype none

package rwam_pkg;

    // default sizes
    localparam int RWAM_QUEUE_DEPTH = 64;
    localparam int RWAM_ADDR_BITS   = 40;
    localparam int RWAM_REF_BITS    = 16;

    // register reset values
    localparam logic [63:0] RST_RANGE_BASE  = 64'h0;
    localparam logic [63:0] RST_RANGE_SIZE  = 64'h10_0000;
    localparam logic [63:0] RST_WINDOW_SIZE = 64'h1_0000;
    localparam logic [63:0] RST_SLOT_SIZE   = 64'h800;

    // register indexes
    localparam logic [1:0] CFG_RANGE_BASE  = 2'd0;
    localparam logic [1:0] CFG_RANGE_SIZE  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd2;
    localparam logic [1:0] CFG_SLOT_SIZE   = 2'd3;

    // request kinds
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_MAPPED = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_RANGE  = 3'd3;
    localparam logic [2:0] ST_SLOTS  = 3'd4;
    localparam logic [2:0] ST_FULL   = 3'd5;

    // translation commands
    localparam logic [1:0] IOP_NONE  = 2'd0;
    localparam logic [1:0] IOP_MAP   = 2'd1;
    localparam logic [1:0] IOP_UNMAP = 2'd2;

    // window queue control
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/rwam_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module rwam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/rwam_queue.sv -----
// fifo of closed windows waiting to become the head window
`default_nettype none

module rwam_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ENTRY_BITS  = 96
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire rwam_pkg::q_ctrl_t       ctrl,
    input  wire logic [ENTRY_BITS-1:0]   push_data,
    output logic      [ENTRY_BITS-1:0]   pop_data,
    output logic                         empty,
    output logic                         full
);
    import rwam_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    // pop data is valid the cycle after ctrl.pop
    rwam_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctrl.push),
        .waddr (wptr_reg),
        .wdata (push_data),
        .re    (ctrl.pop),
        .raddr (rptr_reg),
        .rdata (pop_data)
    );

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(QUEUE_DEPTH));

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (ctrl.push) begin
            wptr_next  = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            count_next = count_next + 1'b1;
        end
        if (ctrl.pop) begin
            rptr_next  = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) ctrl.push |-> !full)
        else $error("push into full window queue");
    assert property (@(posedge aclk) disable iff (!aresetn) ctrl.pop |-> !empty)
        else $error("pop from empty window queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop && !ctrl.push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

// ----- sv/rwam_slot_mul.sv -----
// multi-cycle refs times slot_size multiplier, two half-width partial products
`default_nettype none

module rwam_slot_mul #(
    parameter int ADDR_BITS = 40,
    parameter int REF_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [REF_BITS-1:0]           refs,
    input  wire logic [ADDR_BITS-1:0]          slot,
    output logic                               done,
    output logic      [REF_BITS+ADDR_BITS-1:0] product
);

    localparam int LO = ADDR_BITS / 2;
    localparam int HI = ADDR_BITS - LO;
    localparam int PW = REF_BITS + ADDR_BITS;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    logic [1:0]             phase_reg, phase_next;
    logic                   done_reg, done_next;
    logic [REF_BITS-1:0]    a_reg;
    logic [ADDR_BITS-1:0]   b_reg;
    logic [REF_BITS+LO-1:0] lo_reg;
    logic [REF_BITS+HI-1:0] hi_reg;
    logic [PW-1:0]          prod_reg;

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_IDLE: if (start) phase_next = PH_LO;
            PH_LO:   phase_next = PH_HI;
            PH_HI:   phase_next = PH_SUM;
            PH_SUM: begin
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == PH_IDLE && start) begin
            a_reg <= refs;
            b_reg <= slot;
        end
        if (phase_reg == PH_LO) begin
            lo_reg <= (REF_BITS+LO)'(a_reg) * (REF_BITS+LO)'(b_reg[LO-1:0]);
        end
        if (phase_reg == PH_HI) begin
            hi_reg <= (REF_BITS+HI)'(a_reg) * (REF_BITS+HI)'(b_reg[ADDR_BITS-1:LO]);
        end
        if (phase_reg == PH_SUM) begin
            prod_reg <= (PW'(hi_reg) << LO) + PW'(lo_reg);
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

// ----- sv/refcounted_window_address_mapper.sv -----
// refcounted window address mapper: lays physical buffers on a ring of virtual windows
//
// input channel s_*: one request per transaction, s_tuser = operation (0 map, 1 unmap),
//   s_tdata = phys_base then virt_addr
// result channel m_*: exactly one result transaction per request, in request order
// config channel cfg_*: cfg_index selects range_base, range_size, window_size or
//   slot_size; always ready, write only while no request is in flight
// sequencing: a request is taken in the idle state and the block works on it alone
//   - map that opens a window, whole-range requests, errors: dispatch, then emit
//   - unmap of the current head window: dispatch, unmap check, emit
//   - map of the open window again: dispatch, multiply wait on the slot multiplier, emit
//   - unmap that pops a window from the queue memory: each pop adds the pop wait state
//     for the registered read of the queue ram
// the result sits in an output register; the next request is accepted while it
// waits, and only the final hand-off of that next result waits for m_tready
// reset (aresetn low, synchronous) empties the queue, closes all windows and
// loads the default range, window and slot sizes; the queue ram is not cleared
`default_nettype none

module refcounted_window_address_mapper #(
    parameter int QUEUE_DEPTH = rwam_pkg::RWAM_QUEUE_DEPTH,
    parameter int ADDR_BITS   = rwam_pkg::RWAM_ADDR_BITS,
    parameter int REF_BITS    = rwam_pkg::RWAM_REF_BITS
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    // request channel
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // phys_base, virt_addr
    input  wire logic [((2*ADDR_BITS+7)/8)*8-1:0]         s_tdata,
    // operation
    input  wire logic                                     s_tuser,
    // result channel
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // status, addr_out, iommu_op, iommu_virt, iommu_phys, iommu_size
    output logic      [((4*ADDR_BITS+5+7)/8)*8-1:0]       m_tdata,
    // configuration write channel
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [1:0]                               cfg_index,
    input  wire logic [ADDR_BITS-1:0]                     cfg_data
);
    import rwam_pkg::*;

    localparam int OUT_W      = ((4*ADDR_BITS+5+7)/8)*8;
    localparam int ENTRY_BITS = 2*ADDR_BITS + REF_BITS;
    localparam int PW         = REF_BITS + ADDR_BITS;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_MULWAIT  = 3'd2;
    localparam logic [2:0] S_POPWAIT  = 3'd3;
    localparam logic [2:0] S_UNCHK    = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    // configuration registers
    logic [ADDR_BITS-1:0] range_base_reg, range_size_reg, window_size_reg, slot_size_reg;

    // sequencer and request latch
    logic [2:0]           state_reg, state_next;
    logic                 op_reg;
    logic [ADDR_BITS-1:0] phys_reg, va_reg;
    logic                 pop_ctx_reg, pop_ctx_next;   // 1: pop follows a release

    // open and head windows
    logic                 open_valid_reg, open_valid_next;
    logic [ADDR_BITS-1:0] open_virt_reg, open_virt_next;
    logic [ADDR_BITS-1:0] open_phys_reg, open_phys_next;
    logic [REF_BITS-1:0]  open_refs_reg, open_refs_next;
    logic                 head_valid_reg, head_valid_next;
    logic [ADDR_BITS-1:0] head_virt_reg, head_virt_next;
    logic [ADDR_BITS-1:0] head_phys_reg, head_phys_next;
    logic [REF_BITS-1:0]  head_refs_reg, head_refs_next;

    // pending result
    logic [2:0]           res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0] res_addr_reg, res_addr_next;
    logic [1:0]           res_iop_reg, res_iop_next;
    logic [ADDR_BITS-1:0] res_ivirt_reg, res_ivirt_next;
    logic [ADDR_BITS-1:0] res_iphys_reg, res_iphys_next;
    logic [ADDR_BITS-1:0] res_isize_reg, res_isize_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    // queue and multiplier hookup
    q_ctrl_t               q_ctrl;
    logic [ENTRY_BITS-1:0] q_push_data, q_pop_data;
    logic                  q_empty, q_full;
    logic                  mul_start, mul_done;
    logic [PW-1:0]         mul_product;

    // decode helpers
    logic                 whole_mode;
    logic [ADDR_BITS-1:0] rel, next_virt, va_off, refs_one_addr;
    logic                 wrap;
    logic [REF_BITS-1:0]  head_refs_dec;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    rwam_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (q_ctrl),
        .push_data (q_push_data),
        .pop_data  (q_pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    rwam_slot_mul #(
        .ADDR_BITS (ADDR_BITS),
        .REF_BITS  (REF_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .refs    (open_refs_reg + 1'b1),
        .slot    (slot_size_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // the open window is what gets queued when a new buffer arrives
    assign q_push_data = {open_refs_reg, open_phys_reg, open_virt_reg};

    assign whole_mode = (range_size_reg == window_size_reg);

    // next window on the ring, back to range_base when it would not fit
    assign rel       = open_virt_reg - range_base_reg;
    assign wrap      = (rel >= range_size_reg) || (window_size_reg >= range_size_reg - rel);
    assign next_virt = wrap ? range_base_reg : open_virt_reg + window_size_reg;
    // first slot of a fresh window
    assign refs_one_addr = next_virt + window_size_reg - slot_size_reg;

    assign va_off        = va_reg - head_virt_reg;
    assign head_refs_dec = (head_refs_reg == '0) ? '0 : head_refs_reg - 1'b1;

    always_comb begin
        state_next      = state_reg;
        pop_ctx_next    = pop_ctx_reg;
        open_valid_next = open_valid_reg;
        open_virt_next  = open_virt_reg;
        open_phys_next  = open_phys_reg;
        open_refs_next  = open_refs_reg;
        head_valid_next = head_valid_reg;
        head_virt_next  = head_virt_reg;
        head_phys_next  = head_phys_reg;
        head_refs_next  = head_refs_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_iop_next    = res_iop_reg;
        res_ivirt_next  = res_ivirt_reg;
        res_iphys_next  = res_iphys_reg;
        res_isize_next  = res_isize_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        q_ctrl          = '0;
        mul_start       = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                // errors carry zeros in every address field
                res_status_next = ST_OK;
                res_addr_next   = '0;
                res_iop_next    = IOP_NONE;
                res_ivirt_next  = '0;
                res_iphys_next  = '0;
                res_isize_next  = '0;
                state_next      = S_EMIT;
                if (op_reg == OP_MAP) begin
                    if (whole_mode) begin
                        if (head_valid_reg) begin
                            res_status_next = ST_MAPPED;
                        end else begin
                            head_valid_next = 1'b1;
                            head_virt_next  = range_base_reg;
                            head_phys_next  = phys_reg;
                            head_refs_next  = REF_BITS'(1);
                            res_addr_next   = range_base_reg;
                            res_iop_next    = IOP_MAP;
                            res_ivirt_next  = range_base_reg;
                            res_iphys_next  = phys_reg;
                            res_isize_next  = range_size_reg;
                        end
                    end else if (open_valid_reg && open_phys_reg == phys_reg) begin
                        // another instance in the open window
                        if (&open_refs_reg) begin
                            res_status_next = ST_SLOTS;
                        end else begin
                            mul_start  = 1'b1;
                            state_next = S_MULWAIT;
                        end
                    end else if (slot_size_reg > window_size_reg) begin
                        res_status_next = ST_SLOTS;
                    end else if (open_valid_reg && q_full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        if (open_valid_reg) begin
                            q_ctrl.push    = 1'b1;
                            open_virt_next = next_virt;
                            res_addr_next  = refs_one_addr;
                            res_ivirt_next = next_virt;
                        end else begin
                            // reopen after a drain starts at the range base
                            open_virt_next = range_base_reg;
                            res_addr_next  = range_base_reg + window_size_reg - slot_size_reg;
                            res_ivirt_next = range_base_reg;
                        end
                        open_valid_next = 1'b1;
                        open_phys_next  = phys_reg;
                        open_refs_next  = REF_BITS'(1);
                        res_iop_next    = IOP_MAP;
                        res_iphys_next  = phys_reg;
                        res_isize_next  = window_size_reg;
                    end
                end else begin
                    if (whole_mode) begin
                        if (!head_valid_reg) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            head_valid_next = 1'b0;
                            res_addr_next   = range_base_reg;
                            res_iop_next    = IOP_UNMAP;
                            res_ivirt_next  = range_base_reg;
                            res_isize_next  = range_size_reg;
                        end
                    end else if (head_valid_reg) begin
                        state_next = S_UNCHK;
                    end else if (q_empty) begin
                        res_status_next = ST_EMPTY;
                    end else begin
                        // no head yet: pull the oldest queued window first
                        q_ctrl.pop   = 1'b1;
                        pop_ctx_next = 1'b0;
                        state_next   = S_POPWAIT;
                    end
                end
            end

            S_MULWAIT: begin
                if (mul_done) begin
                    if (mul_product > PW'(window_size_reg)) begin
                        res_status_next = ST_SLOTS;
                    end else begin
                        open_refs_next = open_refs_reg + 1'b1;
                        res_addr_next  = open_virt_reg + window_size_reg
                                       - mul_product[ADDR_BITS-1:0];
                    end
                    state_next = S_EMIT;
                end
            end

            S_POPWAIT: begin
                head_valid_next = 1'b1;
                head_virt_next  = q_pop_data[ADDR_BITS-1:0];
                head_phys_next  = q_pop_data[2*ADDR_BITS-1:ADDR_BITS];
                head_refs_next  = q_pop_data[ENTRY_BITS-1:2*ADDR_BITS];
                state_next      = pop_ctx_reg ? S_EMIT : S_UNCHK;
            end

            S_UNCHK: begin
                state_next = S_EMIT;
                if (va_reg < head_virt_reg || va_off > window_size_reg) begin
                    res_status_next = ST_RANGE;
                end else begin
                    res_addr_next  = head_phys_reg + va_off;
                    head_refs_next = head_refs_dec;
                    if (head_refs_dec == '0) begin
                        // last reference gone: release the window, advance the head
                        res_iop_next    = IOP_UNMAP;
                        res_ivirt_next  = head_virt_reg;
                        res_isize_next  = window_size_reg;
                        head_valid_next = 1'b0;
                        if (!q_empty) begin
                            q_ctrl.pop   = 1'b1;
                            pop_ctx_next = 1'b1;
                            state_next   = S_POPWAIT;
                        end else if (open_valid_reg) begin
                            head_valid_next = 1'b1;
                            head_virt_next  = open_virt_reg;
                            head_phys_next  = open_phys_reg;
                            head_refs_next  = open_refs_reg;
                            open_valid_next = 1'b0;
                        end
                    end
                end
            end

            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({res_isize_reg, res_iphys_reg, res_ivirt_reg,
                                            res_iop_reg, res_addr_reg, res_status_reg});
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            open_valid_reg  <= 1'b0;
            open_virt_reg   <= '0;
            open_phys_reg   <= '0;
            open_refs_reg   <= '0;
            head_valid_reg  <= 1'b0;
            head_virt_reg   <= '0;
            head_phys_reg   <= '0;
            head_refs_reg   <= '0;
            range_base_reg  <= ADDR_BITS'(RST_RANGE_BASE);
            range_size_reg  <= ADDR_BITS'(RST_RANGE_SIZE);
            window_size_reg <= ADDR_BITS'(RST_WINDOW_SIZE);
            slot_size_reg   <= ADDR_BITS'(RST_SLOT_SIZE);
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            open_valid_reg <= open_valid_next;
            open_virt_reg  <= open_virt_next;
            open_phys_reg  <= open_phys_next;
            open_refs_reg  <= open_refs_next;
            head_valid_reg <= head_valid_next;
            head_virt_reg  <= head_virt_next;
            head_phys_reg  <= head_phys_next;
            head_refs_reg  <= head_refs_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RANGE_BASE:  range_base_reg  <= cfg_data;
                    CFG_RANGE_SIZE:  range_size_reg  <= cfg_data;
                    CFG_WINDOW_SIZE: window_size_reg <= cfg_data;
                    CFG_SLOT_SIZE:   slot_size_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser;
            phys_reg <= s_tdata[ADDR_BITS-1:0];
            va_reg   <= s_tdata[2*ADDR_BITS-1:ADDR_BITS];
        end
        pop_ctx_reg    <= pop_ctx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_iop_reg    <= res_iop_next;
        res_ivirt_reg  <= res_ivirt_next;
        res_iphys_reg  <= res_iphys_next;
        res_isize_reg  <= res_isize_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == S_MULWAIT)
        else $error("slot product arrived outside the multiply wait");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("result raised without passing the emit state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POPWAIT |-> $past(q_ctrl.pop))
        else $error("queue data used without a read issued");

endmodule

`default_nettype wire
